// ----- rtl/lws_pkg.sv -----
// Package for the lottery winner select core: field widths, codes,
// microcode word layout and the control store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lws_pkg;

	localparam int OPC_W     = 2;
	localparam int BURST_W   = 16;
	localparam int ID_W      = 22;
	localparam int RND_W     = 31;
	localparam int ST_W      = 3;
	localparam int IDX_OUT_W = 4;
	localparam int TOT_W     = 17;
	localparam int BASE_W    = 8;
	localparam int TICKET_W  = 13;
	localparam int TICKET_MAX = 6808;
	localparam int STEP_W    = 5;
	localparam int DIV_CNT_W = 5;
	localparam int PROD_W    = 32;
	localparam int RECIP_SHIFT = 19;

	localparam logic [BASE_W-1:0]  BASE_RESET = 8'd10;
	localparam logic [BURST_W-1:0] RECIP_10   = 16'd52429;

	localparam logic [OPC_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OPC_W-1:0] OP_DRAW  = 2'd1;
	localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

	typedef enum logic [ST_W-1:0] {
		ST_ADDED   = 3'd0,
		ST_FULL    = 3'd1,
		ST_WINNER  = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_MUL10,
		DP_ADD_WRITE,
		DP_DIV_INIT,
		DP_DIV_STEP,
		DP_WIN_INIT,
		DP_SCAN,
		DP_CLEAR
	} dp_op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_OP_ADD,
		C_OP_DRAW,
		C_OP_CLEAR,
		C_FULL,
		C_EMPTY,
		C_DIV_MORE
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		logic    accept;
		logic    emit;
		status_t status;
		dp_op_t  op;
		cond_t   cond;
		logic    cond_inv;
		step_t   target;
	} ctrl_t;

	typedef struct packed {
		logic beat;
		logic out_free;
		logic op_add;
		logic op_draw;
		logic op_clr;
		logic full;
		logic empty;
		logic div_more;
		logic hit;
	} flags_t;

	localparam step_t S_FETCH     = 5'd0;
	localparam step_t S_DISP_ADD  = 5'd1;
	localparam step_t S_DISP_DRAW = 5'd2;
	localparam step_t S_DISP_CLR  = 5'd3;
	localparam step_t S_DISP_NONE = 5'd4;
	localparam step_t S_ADD       = 5'd5;
	localparam step_t S_ADD_WR    = 5'd6;
	localparam step_t S_EMIT_ADD  = 5'd7;
	localparam step_t S_EMIT_FULL = 5'd8;
	localparam step_t S_DRAW      = 5'd9;
	localparam step_t S_DIV       = 5'd10;
	localparam step_t S_WIN_INIT  = 5'd11;
	localparam step_t S_SCAN_WAIT = 5'd12;
	localparam step_t S_SCAN      = 5'd13;
	localparam step_t S_EMIT_WIN  = 5'd14;
	localparam step_t S_EMIT_EMPTY = 5'd15;
	localparam step_t S_CLEAR     = 5'd16;
	localparam step_t S_EMIT_CLR  = 5'd17;
	localparam step_t S_LAST      = 5'd17;

	function automatic ctrl_t uword(logic acc, logic emt, status_t st, dp_op_t op,
			cond_t c, logic inv, step_t tgt);
		ctrl_t w;
		w.accept   = acc;
		w.emit     = emt;
		w.status   = st;
		w.op       = op;
		w.cond     = c;
		w.cond_inv = inv;
		w.target   = tgt;
		return w;
	endfunction

	// scan loops on a miss: the hit flag enters through cond_inv on C_ALWAYS
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		case (s)
			S_FETCH:      w = uword(1'b1, 1'b0, ST_ADDED, DP_NOP, C_NEXT, 1'b0, S_FETCH);
			S_DISP_ADD:   w = uword(1'b0, 1'b0, ST_ADDED, DP_NOP, C_OP_ADD, 1'b0, S_ADD);
			S_DISP_DRAW:  w = uword(1'b0, 1'b0, ST_ADDED, DP_NOP, C_OP_DRAW, 1'b0, S_DRAW);
			S_DISP_CLR:   w = uword(1'b0, 1'b0, ST_ADDED, DP_NOP, C_OP_CLEAR, 1'b0, S_CLEAR);
			S_DISP_NONE:  w = uword(1'b0, 1'b0, ST_ADDED, DP_NOP, C_ALWAYS, 1'b0, S_FETCH);
			S_ADD:        w = uword(1'b0, 1'b0, ST_ADDED, DP_MUL10, C_FULL, 1'b0,
					S_EMIT_FULL);
			S_ADD_WR:     w = uword(1'b0, 1'b0, ST_ADDED, DP_ADD_WRITE, C_NEXT, 1'b0,
					S_FETCH);
			S_EMIT_ADD:   w = uword(1'b0, 1'b1, ST_ADDED, DP_NOP, C_ALWAYS, 1'b0, S_FETCH);
			S_EMIT_FULL:  w = uword(1'b0, 1'b1, ST_FULL, DP_NOP, C_ALWAYS, 1'b0, S_FETCH);
			S_DRAW:       w = uword(1'b0, 1'b0, ST_ADDED, DP_DIV_INIT, C_EMPTY, 1'b0,
					S_EMIT_EMPTY);
			S_DIV:        w = uword(1'b0, 1'b0, ST_ADDED, DP_DIV_STEP, C_DIV_MORE, 1'b0,
					S_DIV);
			S_WIN_INIT:   w = uword(1'b0, 1'b0, ST_ADDED, DP_WIN_INIT, C_NEXT, 1'b0,
					S_FETCH);
			S_SCAN_WAIT:  w = uword(1'b0, 1'b0, ST_ADDED, DP_NOP, C_NEXT, 1'b0, S_FETCH);
			S_SCAN:       w = uword(1'b0, 1'b0, ST_ADDED, DP_SCAN, C_ALWAYS, 1'b1,
					S_SCAN_WAIT);
			S_EMIT_WIN:   w = uword(1'b0, 1'b1, ST_WINNER, DP_NOP, C_ALWAYS, 1'b0, S_FETCH);
			S_EMIT_EMPTY: w = uword(1'b0, 1'b1, ST_EMPTY, DP_NOP, C_ALWAYS, 1'b0, S_FETCH);
			S_CLEAR:      w = uword(1'b0, 1'b0, ST_ADDED, DP_CLEAR, C_NEXT, 1'b0, S_FETCH);
			S_EMIT_CLR:   w = uword(1'b0, 1'b1, ST_CLEARED, DP_NOP, C_ALWAYS, 1'b0,
					S_FETCH);
			default:      w = uword(1'b0, 1'b0, ST_ADDED, DP_NOP, C_ALWAYS, 1'b0, S_FETCH);
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/lws_if.sv -----
// Request and response channel interfaces of the lottery winner select core.
// Depends on lws_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface lws_in_if;
	import lws_pkg::*;
	logic               valid;
	logic               ready;
	logic [OPC_W-1:0]   opcode;
	logic [BURST_W-1:0] burst_len;
	logic [ID_W-1:0]    process_id;
	logic [RND_W-1:0]   random_value;
	modport source (output valid, output opcode, output burst_len, output process_id,
		output random_value, input ready);
	modport sink (input valid, input opcode, input burst_len, input process_id,
		input random_value, output ready);
endinterface

interface lws_out_if;
	import lws_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ST_W-1:0]      status;
	logic [IDX_OUT_W-1:0] winner_index;
	logic [ID_W-1:0]      winner_id;
	logic [TOT_W-1:0]     pool_tickets;
	modport source (output valid, output status, output winner_index, output winner_id,
		output pool_tickets, input ready);
	modport sink (input valid, input status, input winner_index, input winner_id,
		input pool_tickets, output ready);
endinterface
`default_nettype wire

// ----- rtl/lws_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ----- rtl/lws_seq.sv -----
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on lws_pkg for the control word, flags and the program.
`timescale 1ns / 1ps
`default_nettype none
module lws_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lws_pkg::flags_t flags,
	output lws_pkg::ctrl_t       ctrl
);
	import lws_pkg::*;

	step_t pc_q;
	step_t pc_d;
	logic  take;
	logic  stall;

	assign ctrl = ucode(pc_q);

	always_comb begin
		case (ctrl.cond)
			C_NEXT:     take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_OP_ADD:   take = flags.op_add;
			C_OP_DRAW:  take = flags.op_draw;
			C_OP_CLEAR: take = flags.op_clr;
			C_FULL:     take = flags.full;
			C_EMPTY:    take = flags.empty;
			C_DIV_MORE: take = flags.div_more;
			default:    take = 1'b0;
		endcase
		if (ctrl.cond_inv) begin
			take = take && !flags.hit;
		end
		stall = (ctrl.accept && !flags.beat) || (ctrl.emit && !flags.out_free);
		if (stall) begin
			pc_d = pc_q;
		end else if (take) begin
			pc_d = ctrl.target;
		end else begin
			pc_d = pc_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_FETCH;
		end else begin
			pc_q <= pc_d;
		end
	end

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= S_LAST)
		else $error("step counter left the program");

	a_emit_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && !flags.out_free) |=> (pc_q == $past(pc_q)))
		else $error("result step left while output was occupied");

	a_fetch_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && flags.out_free) |=> (pc_q == S_FETCH))
		else $error("result step did not return to fetch");
endmodule
`default_nettype wire

// ----- rtl/lws_dp.sv -----
// Datapath: input latch, ticket arithmetic, serial modulo, table scan,
// contender RAM and the output register. Depends on lws_pkg, lws_if, lws_ram.
`timescale 1ns / 1ps
`default_nettype none
module lws_dp #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lws_pkg::BASE_W-1:0]    cfg_data,
	input  wire lws_pkg::ctrl_t                ctrl,
	output lws_pkg::flags_t                    flags,
	lws_in_if.sink                             req,
	lws_out_if.source                          rsp
);
	import lws_pkg::*;

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int SUM_W  = $clog2(MAX_ENTRIES * TICKET_MAX + 1);
	localparam int WORD_W = TICKET_W + ID_W;

	logic [BASE_W-1:0]    base_q;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [OPC_W-1:0]     opc_q;
	logic [BURST_W-1:0]   burst_q;
	logic [ID_W-1:0]      pid_q;
	logic [RND_W-1:0]     dvd_q;
	logic [PROD_W-1:0]    prod_q;
	logic [SUM_W-1:0]     rem_q;
	logic [SUM_W-1:0]     win_q;
	logic [SUM_W-1:0]     acc_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [IDX_W-1:0]     scan_idx_q;
	logic [IDX_W-1:0]     win_idx_q;
	logic [ID_W-1:0]      win_id_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [IDX_OUT_W-1:0] out_idx_q;
	logic [ID_W-1:0]      out_id_q;
	logic [TOT_W-1:0]     out_tot_q;

	logic                 beat;
	logic                 out_free;
	logic                 load_out;
	logic [TICKET_W-1:0]  ticket;
	logic [SUM_W:0]       trial;
	logic                 trial_ge;
	logic [SUM_W:0]       acc_new;
	logic                 hit;
	logic                 ram_we;
	logic [WORD_W-1:0]    ram_wdata;
	logic [WORD_W-1:0]    ram_rdata;
	logic [TICKET_W-1:0]  rd_ticket;
	logic [ID_W-1:0]      rd_id;

	assign req.ready = ctrl.accept;
	assign beat      = req.valid && ctrl.accept;
	assign out_free  = !out_valid_q || rsp.ready;
	assign load_out  = ctrl.emit && out_free;

	assign ticket    = prod_q[PROD_W-1 -: TICKET_W] + TICKET_W'(base_q);
	assign trial     = {rem_q, dvd_q[RND_W-1]};
	assign trial_ge  = trial >= {1'b0, sum_q};
	assign rd_ticket = ram_rdata[ID_W +: TICKET_W];
	assign rd_id     = ram_rdata[ID_W-1:0];
	assign acc_new   = {1'b0, acc_q} + (SUM_W + 1)'(rd_ticket);
	assign hit       = acc_new >= {1'b0, win_q};

	assign ram_we    = (ctrl.op == DP_ADD_WRITE);
	assign ram_wdata = {ticket, pid_q};

	always_comb begin
		flags.beat     = beat;
		flags.out_free = out_free;
		flags.op_add   = (opc_q == OP_ADD);
		flags.op_draw  = (opc_q == OP_DRAW);
		flags.op_clr   = (opc_q == OP_CLEAR);
		flags.full     = (count_q == CNT_W'(MAX_ENTRIES));
		flags.empty    = (count_q == '0) || (sum_q == '0);
		flags.div_more = (div_cnt_q != '0);
		flags.hit      = hit;
	end

	lws_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (ram_wdata),
		.raddr (scan_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_RESET;
			count_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_data;
			end
			case (ctrl.op)
				DP_ADD_WRITE: begin
					count_q <= count_q + CNT_W'(1);
					sum_q   <= sum_q + SUM_W'(ticket);
				end
				DP_CLEAR: begin
					count_q <= '0;
					sum_q   <= '0;
				end
				default: begin
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat) begin
			opc_q   <= req.opcode;
			burst_q <= req.burst_len;
			pid_q   <= req.process_id;
			dvd_q   <= req.random_value;
		end
		case (ctrl.op)
			DP_MUL10: begin
				prod_q <= PROD_W'(burst_q) * PROD_W'(RECIP_10);
			end
			DP_DIV_INIT: begin
				rem_q     <= '0;
				div_cnt_q <= DIV_CNT_W'(RND_W - 1);
			end
			DP_DIV_STEP: begin
				rem_q     <= trial_ge ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
				dvd_q     <= {dvd_q[RND_W-2:0], 1'b0};
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end
			DP_WIN_INIT: begin
				win_q      <= rem_q + SUM_W'(1);
				acc_q      <= '0;
				scan_idx_q <= '0;
			end
			DP_SCAN: begin
				acc_q      <= acc_new[SUM_W-1:0];
				scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (hit) begin
					win_idx_q <= scan_idx_q;
					win_id_q  <= rd_id;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_status_q <= ctrl.status;
			out_tot_q    <= TOT_W'(sum_q);
			if (ctrl.status == ST_WINNER) begin
				out_idx_q <= IDX_OUT_W'(win_idx_q);
				out_id_q  <= win_id_q;
			end else begin
				out_idx_q <= '0;
				out_id_q  <= '0;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.winner_index  = out_idx_q;
	assign rsp.winner_id     = out_id_q;
	assign rsp.pool_tickets  = out_tot_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above table size");

	a_empty_no_tickets: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (sum_q == '0))
		else $error("tickets present in an empty table");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == DP_SCAN) |-> (CNT_W'(scan_idx_q) < count_q))
		else $error("scan ran past the filled entries");

	a_rem_below_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == DP_DIV_STEP) |-> (rem_q < sum_q))
		else $error("partial remainder not below ticket total");
endmodule
`default_nettype wire

// ----- rtl/lottery_winner_select_core.sv -----
// Lottery winner select: from accepted beat to result, an add runs dispatch, multiply and write
// (write skipped when full), a clear runs dispatch and clear; a draw runs the 31-step serial
// modulo (skipped on an empty table), then a RAM read and a compare per scanned entry.
// One item at a time: the next beat can be taken in the cycle after the result loads;
// a result step holds while the output register is full and not being read.
// Reset clears entry count, ticket total and output valid; ticket base returns to 10.
`timescale 1ns / 1ps
`default_nettype none
module lottery_winner_select_core #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [lws_pkg::BASE_W-1:0] cfg_data,
	lws_in_if.sink                          req,
	lws_out_if.source                       rsp
);
	import lws_pkg::*;

	ctrl_t  ctrl;
	flags_t flags;

	lws_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	lws_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.ctrl     (ctrl),
		.flags    (flags),
		.req      (req),
		.rsp      (rsp)
	);
endmodule
`default_nettype wire

// ----- tb/lottery_winner_select_core_checker.sv -----
// Checker for the lottery winner select core: tracks ticket base, table and total,
// predicts the response to every add, draw and clear beat and compares response beats in order.
// Depends on lws_pkg and the channel interfaces in lws_if.sv.
`timescale 1ns / 1ps
module lottery_winner_select_core_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [lws_pkg::BASE_W-1:0] cfg_data,
	lws_in_if                               req,
	lws_out_if                              rsp,
	output int                              fail_count,
	output int                              pending
);
	import lws_pkg::*;

	localparam int TABLE_DEPTH = 16;

	typedef struct packed {
		status_t              status;
		logic [IDX_OUT_W-1:0] index;
		logic [ID_W-1:0]      id;
		logic [TOT_W-1:0]     total;
	} outcome_t;

	logic [BASE_W-1:0]   base;
	int unsigned         entries;
	logic [TOT_W-1:0]    ticket_total;
	logic [TICKET_W-1:0] tickets [TABLE_DEPTH];
	logic [ID_W-1:0]     ids [TABLE_DEPTH];
	outcome_t            outcome_q [$];
	int                  errs = 0;
	outcome_t            want;
	outcome_t            got;
	outcome_t            fresh;
	bit                  produced;

	task automatic run_lottery_item(input logic [OPC_W-1:0] op,
			input logic [BURST_W-1:0] burst, input logic [ID_W-1:0] pid,
			input logic [RND_W-1:0] rnd, output bit has_result, output outcome_t o);
		logic [TICKET_W-1:0] t;
		logic [31:0]         winning;
		logic [31:0]         acc;
		bit                  found;
		o = '{ST_ADDED, '0, '0, '0};
		has_result = 1'b1;
		case (op)
			OP_ADD: begin
				if (entries >= TABLE_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					t = TICKET_W'(burst / 10 + base);
					tickets[entries] = t;
					ids[entries] = pid;
					entries++;
					ticket_total = ticket_total + t;
				end
			end
			OP_DRAW: begin
				o.status = ST_EMPTY;
				if (entries != 0 && ticket_total != 0) begin
					winning = 32'(rnd) % 32'(ticket_total) + 1;
					acc = 0;
					found = 1'b0;
					for (int i = 0; i < entries; i++) begin
						if (!found) begin
							acc = acc + tickets[i];
							if (acc >= winning) begin
								found = 1'b1;
								o.status = ST_WINNER;
								o.index = IDX_OUT_W'(i);
								o.id = ids[i];
							end
						end
					end
				end
			end
			OP_CLEAR: begin
				entries = 0;
				ticket_total = '0;
				o.status = ST_CLEARED;
			end
			default: has_result = 1'b0;
		endcase
		o.total = ticket_total;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errs++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base = BASE_RESET;
			entries = 0;
			ticket_total = '0;
			outcome_q.delete();
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{status_t'(rsp.status), rsp.winner_index, rsp.winner_id,
					rsp.pool_tickets};
				if (outcome_q.size() == 0) begin
					errs++;
					$display("%0t: response beat with none expected: status %0d id %0d",
						$time, got.status, got.id);
				end else begin
					want = outcome_q.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("winner_index", 32'(want.index), 32'(got.index));
					check_field("winner_id", 32'(want.id), 32'(got.id));
					check_field("pool_tickets", 32'(want.total), 32'(got.total));
				end
			end
			if (req.valid && req.ready) begin
				run_lottery_item(req.opcode, req.burst_len, req.process_id,
					req.random_value, produced, fresh);
				if (produced)
					outcome_q.push_back(fresh);
			end
			if (cfg_we)
				base = cfg_data;
			fail_count <= errs;
			pending <= outcome_q.size();
		end
	end

endmodule

// ----- tb/lottery_winner_select_core_tb.sv -----
// Top of the lottery winner select core testbench: clock, reset, request stimulus,
// response back-pressure, ticket base writes and the verdict.
// Depends on lws_pkg, lws_if.sv, the core and lottery_winner_select_core_checker.
`timescale 1ns / 1ps
module lottery_winner_select_core_tb;
	import lws_pkg::*;

	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 305;
	localparam int SETTLE_CYCLES = 100;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [BASE_W-1:0] cfg_data;
	int                fail_count;
	int                pending;
	bit                steady;
	int                rsp_hold;
	int                stall_draw;

	lws_in_if  req_if ();
	lws_out_if rsp_if ();

	lottery_winner_select_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	lottery_winner_select_core_checker lottery_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.req        (req_if),
		.rsp        (rsp_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("** lottery_winner_select_core: FAILED **");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			rsp_hold <= 0;
		end else if (rsp_if.valid && rsp_if.ready) begin
			stall_draw = steady ? 0 : $urandom_range(0, 15);
			rsp_hold <= stall_draw;
			rsp_if.ready <= (stall_draw == 0);
		end else if (rsp_hold != 0) begin
			rsp_hold <= rsp_hold - 1;
			rsp_if.ready <= (rsp_hold == 1);
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	task automatic send_item(input logic [OPC_W-1:0] op, input logic [BURST_W-1:0] burst,
			input logic [ID_W-1:0] pid, input logic [RND_W-1:0] rnd);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.opcode <= op;
		req_if.burst_len <= burst;
		req_if.process_id <= pid;
		req_if.random_value <= rnd;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_base(input logic [BASE_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [BASE_W-1:0]  phase_base [6];
		logic [OPC_W-1:0]   op;
		logic [BURST_W-1:0] burst;
		logic [ID_W-1:0]    pid;
		logic [RND_W-1:0]   rnd;
		int                 pick;
		int                 issued;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		req_if.valid <= 1'b0;
		req_if.opcode <= OP_ADD;
		req_if.burst_len <= '0;
		req_if.process_id <= '0;
		req_if.random_value <= '0;
		steady = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset ticket base: empty table, ignored opcode, field extremes
		send_item(OP_DRAW, '0, '0, '0);
		send_item(OP_CLEAR, '0, '0, '0);
		send_item(OP_UNUSED, '1, '1, '1);
		send_item(OP_ADD, '0, '0, '0);
		send_item(OP_ADD, '1, '1, '0);
		send_item(OP_DRAW, '0, '0, '0);
		send_item(OP_DRAW, '0, '0, '1);
		send_item(OP_CLEAR, '0, '0, '0);

		// zero base: entries present but no tickets
		set_base(8'd0);
		send_item(OP_ADD, 16'd9, 22'h15555, '0);
		send_item(OP_ADD, 16'd5, 22'h2AAAA, '0);
		send_item(OP_DRAW, '0, '0, 31'h5555_5555);
		send_item(OP_CLEAR, '0, '0, '0);

		// top base: fill to the largest total, reject when full
		set_base(8'd255);
		for (int i = 0; i < 16; i++)
			send_item(OP_ADD, '1, 22'(i * 262143), '0);
		send_item(OP_ADD, '1, '1, '0);
		send_item(OP_DRAW, '0, '0, '1);

		phase_base[0] = 8'd255;
		phase_base[1] = 8'($urandom);
		phase_base[2] = BASE_RESET;
		phase_base[3] = 8'd0;
		phase_base[4] = 8'($urandom);
		phase_base[5] = 8'd1;
		for (int ph = 0; ph < 6; ph++) begin
			set_base(phase_base[ph]);
			steady = (ph % 3 == 1);
			issued = 0;
			while (issued < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					op = OP_ADD;
				else if (pick < 94)
					op = OP_DRAW;
				else if (pick < 97)
					op = OP_CLEAR;
				else
					op = OP_UNUSED;
				case ($urandom_range(0, 9))
					0, 1: burst = 16'($urandom_range(0, 9));
					2: burst = '1;
					3: burst = 16'($urandom_range(65526, 65535));
					default: burst = 16'($urandom);
				endcase
				case ($urandom_range(0, 9))
					0: pid = '0;
					1: pid = '1;
					default: pid = 22'($urandom);
				endcase
				case ($urandom_range(0, 9))
					0: rnd = '0;
					1: rnd = '1;
					default: rnd = 31'($urandom);
				endcase
				send_item(op, burst, pid, rnd);
				if (op != OP_UNUSED)
					issued++;
			end
		end

		steady = 1'b0;
		drain();
		if (fail_count == 0 && pending == 0) begin
			$display("** lottery_winner_select_core: PASSED **");
		end else begin
			$display("** lottery_winner_select_core: FAILED **");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/lws_pkg.sv
rtl/lws_if.sv
rtl/lws_ram.sv
rtl/lws_seq.sv
rtl/lws_dp.sv
rtl/lottery_winner_select_core.sv
tb/lottery_winner_select_core_checker.sv
tb/lottery_winner_select_core_tb.sv
